### src/lts_pkg.sv
// Shared types, constants and character helpers for the lexical token scanner.
`default_nettype none
package lts_pkg;

  localparam int MAX_LEXEME    = 64;
  localparam int POSITION_BITS = 16;
  localparam int LEN_W         = 7;
  localparam int KW_COUNT      = 14;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POSITION_BITS-1:0] pos_t;

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_REL, M_NUM, M_EXP, M_EXPD, M_IDENT, M_LIT
  } mode_t;

  typedef enum logic [4:0] {
    TK_NUM  = 5'd0,  TK_LIT  = 5'd1,  TK_ID   = 5'd2,  TK_EOF  = 5'd3,
    TK_OPR  = 5'd4,  TK_RCB  = 5'd5,  TK_OPM  = 5'd6,  TK_AB_P = 5'd7,
    TK_FC_P = 5'd8,  TK_PT_V = 5'd9,  TK_VIR  = 5'd10, TK_KW0  = 5'd11,
    TK_ERRO = 5'd25
  } tok_class_t;

  localparam logic signed [2:0] VT_NONE = -3'sd1;
  localparam logic signed [2:0] VT_INT  = 3'sd0;
  localparam logic signed [2:0] VT_REAL = 3'sd1;
  localparam logic signed [2:0] VT_LIT  = 3'sd2;

  typedef struct packed {
    logic [4:0]        cls;
    logic signed [2:0] vtype;
    logic [LEN_W-1:0]  len;
    logic [7:0]        c1;
    logic [7:0]        c2;
    pos_t              line;
    pos_t              col;
    logic              last;
  } token_t;

  // keyword text, right-justified, first character in the highest used byte
  localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
    72'("inicio"), 72'("varinicio"), 72'("varfim"), 72'("escreva"), 72'("leia"),
    72'("se"), 72'("entao"), 72'("fimse"), 72'("repita"), 72'("fimrepita"),
    72'("fim"), 72'("inteiro"), 72'("literal"), 72'("real")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd9, 4'd6, 4'd7, 4'd4, 4'd2, 4'd5, 4'd5, 4'd6, 4'd9, 4'd3, 4'd7, 4'd7, 4'd4
  };
  localparam logic signed [2:0] KW_TYPE [KW_COUNT] = '{
    VT_NONE, VT_NONE, VT_NONE, VT_NONE, VT_NONE, VT_NONE, VT_NONE,
    VT_NONE, VT_NONE, VT_NONE, VT_NONE, VT_INT, VT_LIT, VT_REAL
  };

  function automatic pos_t pos_inc(input pos_t v);
    return (v == '1) ? v : v + pos_t'(1);
  endfunction

  function automatic logic [LEN_W-1:0] len_grow(input logic [LEN_W-1:0] v);
    return (v < LEN_W'(MAX_LEXEME)) ? v + LEN_W'(1) : v;
  endfunction

  // clears the bit of every keyword whose character at position p is not c
  function automatic logic [KW_COUNT-1:0] kw_track(input logic [KW_COUNT-1:0] alive,
                                                   input logic [LEN_W-1:0] p,
                                                   input logic [7:0] c);
    logic [KW_COUNT-1:0] m;
    logic [71:0]         sh;
    m = alive;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (p >= LEN_W'(KW_LEN[k])) begin
        m[k] = 1'b0;
      end else begin
        sh = KW_TEXT[k] >> (8 * (int'(KW_LEN[k]) - 1 - int'(p)));
        if (sh[7:0] != c) m[k] = 1'b0;
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

### src/lts_front.sv
// Front end: character classification and scanner state, up to two tokens per character.
`default_nettype none
module lts_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    c,
  input  wire logic          eoi,
  output lts_pkg::token_t    tok0,
  output lts_pkg::token_t    tok1,
  output logic               push0,
  output logic               push1
);
  import lts_pkg::*;

  mode_t               mode, mode_next;
  logic [7:0]          pend, pend_next;
  logic [LEN_W-1:0]    tlen, tlen_next;
  logic [KW_COUNT-1:0] kwa, kwa_next;
  logic                real_s, real_s_next;
  pos_t                line_c, line_c_next, col_c, col_c_next;
  pos_t                tok_line, tok_line_next, tok_col, tok_col_next;

  pos_t   col;
  logic   is_dig, is_alp, is_quote, again;
  token_t ft, st, pt;
  logic   st_v, pt_v;
  logic   kw_hit;

  always_comb begin
    col      = pos_inc(col_c);
    is_dig   = (c >= "0") && (c <= "9");
    is_alp   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    is_quote = (c == "\"") || (c == "'");

    // token that the open state would give if closed now
    ft       = '0;
    ft.c1    = pend;
    ft.line  = tok_line;
    ft.col   = tok_col;
    ft.len   = tlen;
    ft.vtype = VT_NONE;
    kw_hit   = 1'b0;
    case (mode)
      M_REL: begin
        ft.cls = TK_OPR;
        ft.len = LEN_W'(1);
      end
      M_NUM, M_EXP, M_EXPD: begin
        ft.cls   = TK_NUM;
        ft.vtype = real_s ? VT_REAL : VT_INT;
      end
      M_IDENT: begin
        ft.cls = TK_ID;
        for (int k = 0; k < KW_COUNT; k++) begin
          if (!kw_hit && kwa[k] && (LEN_W'(KW_LEN[k]) == tlen)) begin
            kw_hit   = 1'b1;
            ft.cls   = 5'(int'(TK_KW0) + k);
            ft.vtype = KW_TYPE[k];
          end
        end
      end
      M_LIT: begin
        ft.cls   = TK_LIT;
        ft.vtype = VT_LIT;
      end
      default: ft.cls = TK_ERRO;
    endcase

    // single-character token started by c
    st       = '0;
    st.c1    = c;
    st.len   = LEN_W'(1);
    st.vtype = VT_NONE;
    st.line  = line_c;
    st.col   = col;
    st_v     = 1'b1;
    if (c == " " || c == "\n" || c == "\t" || c == "{" || c == "<" || c == ">" ||
        c == "=" || is_dig || is_alp || is_quote) st_v = 1'b0;
    if (c == "+" || c == "-" || c == "*" || c == "/") st.cls = TK_OPM;
    else if (c == "(" || c == ".")                     st.cls = TK_AB_P;
    else if (c == ")")                                 st.cls = TK_FC_P;
    else if (c == ";")                                 st.cls = TK_PT_V;
    else if (c == ",")                                 st.cls = TK_VIR;
    else                                               st.cls = TK_ERRO;

    mode_next     = mode;
    pend_next     = pend;
    tlen_next     = tlen;
    kwa_next      = kwa;
    real_s_next   = real_s;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    pt            = ft;
    pt_v          = 1'b0;
    again         = 1'b0;

    if (eoi) begin
      pt_v      = (mode != M_IDLE) && (mode != M_COMMENT);
      mode_next = M_IDLE;
      st        = '0;
      st.cls    = TK_EOF;
      st.vtype  = VT_NONE;
      st.line   = line_c;
      st.col    = col;
      st_v      = 1'b1;
    end else begin
      case (mode)
        M_COMMENT: if (c == "}") mode_next = M_IDLE;
        M_REL: begin
          if ((pend == "<" && c == "-") || c == "=") begin
            pt_v      = 1'b1;
            pt.cls    = (pend == "<" && c == "-") ? TK_RCB : TK_OPR;
            pt.len    = LEN_W'(2);
            pt.c2     = c;
            mode_next = M_IDLE;
          end else again = 1'b1;
        end
        M_NUM: begin
          if (is_dig || c == ".") begin
            if (c == ".") real_s_next = 1'b1;
            tlen_next = len_grow(tlen);
          end else if (c == "E" || c == "e") begin
            real_s_next = 1'b1;
            tlen_next   = len_grow(tlen);
            mode_next   = M_EXP;
          end else again = 1'b1;
        end
        M_EXP: begin
          if (c == "+" || c == "-" || is_dig) begin
            tlen_next = len_grow(tlen);
            mode_next = M_EXPD;
          end else again = 1'b1;
        end
        M_EXPD: begin
          if (is_dig) tlen_next = len_grow(tlen);
          else again = 1'b1;
        end
        M_IDENT: begin
          if (is_alp || is_dig || c == "_") begin
            kwa_next  = kw_track(kwa, tlen, c);
            tlen_next = len_grow(tlen);
          end else again = 1'b1;
        end
        M_LIT: begin
          tlen_next = len_grow(tlen);
          if (is_quote) begin
            pt_v      = 1'b1;
            pt.len    = len_grow(tlen);
            mode_next = M_IDLE;
          end
        end
        default: ;
      endcase

      if (again) pt_v = 1'b1;
      if (mode == M_IDLE || again) begin
        mode_next = M_IDLE;
        if (c == "{") mode_next = M_COMMENT;
        else if (c == "<" || c == ">" || c == "=" || is_dig || is_alp || is_quote) begin
          mode_next     = (c == "<" || c == ">" || c == "=") ? M_REL :
                          is_dig ? M_NUM : is_alp ? M_IDENT : M_LIT;
          pend_next     = c;
          tlen_next     = LEN_W'(1);
          real_s_next   = 1'b0;
          tok_line_next = line_c;
          tok_col_next  = col;
          if (is_alp) kwa_next = kw_track('1, '0, c);
        end
      end else begin
        st_v = 1'b0;
      end
    end

    line_c_next = line_c;
    col_c_next  = col_c;
    if (!eoi) begin
      if (c == "\n") begin
        line_c_next = pos_inc(line_c);
        col_c_next  = '0;
      end else col_c_next = col;
    end

    tok0       = pt_v ? pt : st;
    tok0.last  = !(pt_v && st_v);
    tok1       = st;
    tok1.last  = 1'b1;
    push0      = take && (pt_v || st_v);
    push1      = take && pt_v && st_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      pend     <= '0;
      tlen     <= '0;
      kwa      <= '1;
      real_s   <= 1'b0;
      line_c   <= pos_t'(1);
      col_c    <= '0;
      tok_line <= pos_t'(1);
      tok_col  <= pos_t'(1);
    end else if (take) begin
      mode     <= mode_next;
      pend     <= pend_next;
      tlen     <= tlen_next;
      kwa      <= kwa_next;
      real_s   <= real_s_next;
      line_c   <= line_c_next;
      col_c    <= col_c_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
    end
  end

endmodule
`default_nettype wire

### src/lts_queue.sv
// Back end: short token queue, two writes and one combinational read per cycle.
`default_nettype none
module lts_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  lts_pkg::token_t        wd0,
  input  lts_pkg::token_t        wd1,
  input  wire logic              push0,
  input  wire logic              push1,
  input  wire logic              pop,
  output lts_pkg::token_t        rd,
  output logic                   rd_v,
  output logic                   room2,
  output logic [lts_pkg::QCNT_W-1:0] count
);
  import lts_pkg::*;

  token_t            slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QCNT_W-1:0] count_next;

  always_comb begin
    count_next = count + QCNT_W'(push0) + QCNT_W'(push1) - QCNT_W'(pop);
    rd         = slot[rp];
    rd_v       = (count != '0);
    room2      = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  end

  always_ff @(posedge clk) begin
    if (push0) slot[wp] <= wd0;
    if (push1) slot[wp + QPTR_W'(1)] <= wd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + QPTR_W'(push0) + QPTR_W'(push1);
      rp    <= rp + QPTR_W'(pop);
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

### src/lexical_token_scanner.sv
// Top level of the lexical token scanner: front end, token queue and stream ports.
// Takes one source character per request and gives classified tokens (class, value
// type, length, first and second character, 1-based line and column). A character
// that closes a token and starts another gives two tokens; tlast marks the last
// token of each request. One character is taken per cycle while the four-entry
// token queue has room for two tokens, so the rate is one character per cycle
// when at most one token results and the sink keeps up; the output port drains one
// token per cycle and sets the sustained rate for two-token characters.
`default_nettype none
module lexical_token_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tuser,   // [0] end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [4:0] token_class, [7:5] value_type,
                                      // [14:8] lexeme_length, [22:15] first_char,
                                      // [30:23] second_char, [46:31] start_line,
                                      // [62:47] start_column, [63] zero
  output logic             m_tlast    // last_of_run
);
  import lts_pkg::*;

  token_t            tok0, tok1, head;
  logic              push0, push1, take, room2;
  logic [QCNT_W-1:0] count;

  assign take = s_tvalid && s_tready;

  lts_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .c    (s_tdata),
    .eoi  (s_tuser),
    .tok0 (tok0),
    .tok1 (tok1),
    .push0(push0),
    .push1(push1)
  );

  lts_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wd0  (tok0),
    .wd1  (tok1),
    .push0(push0),
    .push1(push1),
    .pop  (m_tvalid && m_tready),
    .rd   (head),
    .rd_v (m_tvalid),
    .room2(room2),
    .count(count)
  );

  assign s_tready = room2;
  assign m_tdata  = {1'b0, head.col, head.line, head.c2, head.c1, head.len,
                     head.vtype, head.cls};
  assign m_tlast  = head.last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("token queue overflow");
  a_eof_out: assert property (@(posedge clk) disable iff (rst)
    (take && s_tuser) |=> m_tvalid) else $error("end of input gave no token");
  a_pair: assert property (@(posedge clk) disable iff (rst)
    push1 |-> push0) else $error("second token without first");
`endif

endmodule
`default_nettype wire

### bench/tb_lexical_token_scanner.sv
// Self-checking bench for the lexical token scanner: random stalls, scoreboarded tokens.
`default_nettype none

class token_scoreboard;
  // scanner state mirrored from the block
  lts_pkg::mode_t        mode;
  logic [7:0]            first_c;
  logic [6:0]            tok_len;
  logic [13:0]           kw_live;
  bit                    is_real;
  lts_pkg::pos_t         line_no, col_no, tok_line, tok_col;
  logic [63:0]           want_data[$];
  bit                    want_last[$];
  int                    errors;
  logic [63:0]           step_tok[$];

  function new();
    mode = lts_pkg::M_IDLE; first_c = 0; tok_len = 0; kw_live = '1; is_real = 0;
    line_no = 1; col_no = 0; tok_line = 1; tok_col = 1; errors = 0;
  endfunction

  function void push(logic [4:0] cls, logic signed [2:0] vt, logic [6:0] len,
                     logic [7:0] c1, logic [7:0] c2, lts_pkg::pos_t ln, lts_pkg::pos_t cl);
    if (step_tok.size() < 2) step_tok.push_back({1'b0, cl, ln, c2, c1, len, vt, cls});
  endfunction

  function bit is_dig(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
  function bit is_let(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function void lengthen();
    if (tok_len < 7'(lts_pkg::MAX_LEXEME)) tok_len++;
  endfunction

  function void match_kw(logic [7:0] c);
    logic [71:0] sh;
    for (int k = 0; k < lts_pkg::KW_COUNT; k++) begin
      if (tok_len >= 7'(lts_pkg::KW_LEN[k])) kw_live[k] = 0;
      else begin
        sh = lts_pkg::KW_TEXT[k] >> (8 * (int'(lts_pkg::KW_LEN[k]) - 1 - int'(tok_len)));
        if (sh[7:0] != c) kw_live[k] = 0;
      end
    end
  endfunction

  function void open_tok(lts_pkg::mode_t m, logic [7:0] c, lts_pkg::pos_t ln,
                         lts_pkg::pos_t cl);
    mode = m; first_c = c; tok_len = 1; is_real = 0; tok_line = ln; tok_col = cl;
  endfunction

  function void close_tok();
    int k;
    case (mode)
      lts_pkg::M_REL: push(lts_pkg::TK_OPR, lts_pkg::VT_NONE, 1, first_c, 0, tok_line, tok_col);
      lts_pkg::M_NUM, lts_pkg::M_EXP, lts_pkg::M_EXPD:
        push(lts_pkg::TK_NUM, is_real ? lts_pkg::VT_REAL : lts_pkg::VT_INT, tok_len,
             first_c, 0, tok_line, tok_col);
      lts_pkg::M_IDENT: begin
        for (k = 0; k < lts_pkg::KW_COUNT; k++)
          if (kw_live[k] && 7'(lts_pkg::KW_LEN[k]) == tok_len) break;
        if (k < lts_pkg::KW_COUNT)
          push(5'(lts_pkg::TK_KW0 + k), lts_pkg::KW_TYPE[k], tok_len, first_c, 0,
               tok_line, tok_col);
        else push(lts_pkg::TK_ID, lts_pkg::VT_NONE, tok_len, first_c, 0, tok_line, tok_col);
      end
      lts_pkg::M_LIT: push(lts_pkg::TK_LIT, lts_pkg::VT_LIT, tok_len, first_c, 0,
                           tok_line, tok_col);
      default: ;
    endcase
    mode = lts_pkg::M_IDLE;
  endfunction

  function void begin_tok(logic [7:0] c, lts_pkg::pos_t ln, lts_pkg::pos_t cl);
    if (c == " " || c == "\n" || c == "\t") return;
    if (c == "{") begin mode = lts_pkg::M_COMMENT; return; end
    if (c == "<" || c == ">" || c == "=") begin open_tok(lts_pkg::M_REL, c, ln, cl); return; end
    if (is_dig(c)) begin open_tok(lts_pkg::M_NUM, c, ln, cl); return; end
    if (is_let(c)) begin
      open_tok(lts_pkg::M_IDENT, c, ln, cl);
      kw_live = '1; tok_len = 0; match_kw(c); tok_len = 1;
      return;
    end
    if (c == "\"" || c == "'") begin open_tok(lts_pkg::M_LIT, c, ln, cl); return; end
    if (c == "+" || c == "-" || c == "*" || c == "/")
      push(lts_pkg::TK_OPM, lts_pkg::VT_NONE, 1, c, 0, ln, cl);
    else if (c == "(" || c == ".") push(lts_pkg::TK_AB_P, lts_pkg::VT_NONE, 1, c, 0, ln, cl);
    else if (c == ")") push(lts_pkg::TK_FC_P, lts_pkg::VT_NONE, 1, c, 0, ln, cl);
    else if (c == ";") push(lts_pkg::TK_PT_V, lts_pkg::VT_NONE, 1, c, 0, ln, cl);
    else if (c == ",") push(lts_pkg::TK_VIR, lts_pkg::VT_NONE, 1, c, 0, ln, cl);
    else push(lts_pkg::TK_ERRO, lts_pkg::VT_NONE, 1, c, 0, ln, cl);
  endfunction

  // note an accepted request and queue the tokens it should give
  function void note_request(logic [7:0] c, bit eoi);
    lts_pkg::pos_t ln, cl;
    bit redo;
    ln = line_no; cl = lts_pkg::pos_inc(col_no); redo = 0;
    step_tok.delete();
    if (eoi) begin
      if (mode == lts_pkg::M_COMMENT) mode = lts_pkg::M_IDLE;
      close_tok();
      push(lts_pkg::TK_EOF, lts_pkg::VT_NONE, 0, 0, 0, ln, cl);
    end else begin
      case (mode)
        lts_pkg::M_COMMENT: if (c == "}") mode = lts_pkg::M_IDLE;
        lts_pkg::M_REL:
          if ((first_c == "<" && c == "-") || c == "=") begin
            push((first_c == "<" && c == "-") ? lts_pkg::TK_RCB : lts_pkg::TK_OPR,
                 lts_pkg::VT_NONE, 2, first_c, c, tok_line, tok_col);
            mode = lts_pkg::M_IDLE;
          end else redo = 1;
        lts_pkg::M_NUM:
          if (is_dig(c) || c == ".") begin if (c == ".") is_real = 1; lengthen(); end
          else if (c == "E" || c == "e") begin
            is_real = 1; lengthen(); mode = lts_pkg::M_EXP;
          end
          else redo = 1;
        lts_pkg::M_EXP:
          if (c == "+" || c == "-" || is_dig(c)) begin lengthen(); mode = lts_pkg::M_EXPD; end
          else redo = 1;
        lts_pkg::M_EXPD: if (is_dig(c)) lengthen(); else redo = 1;
        lts_pkg::M_IDENT:
          if (is_let(c) || is_dig(c) || c == "_") begin match_kw(c); lengthen(); end
          else redo = 1;
        lts_pkg::M_LIT: begin
          lengthen();
          if (c == "\"" || c == "'") close_tok();
        end
        default: begin_tok(c, ln, cl);
      endcase
      if (redo) begin close_tok(); begin_tok(c, ln, cl); end
      if (c == "\n") begin line_no = lts_pkg::pos_inc(line_no); col_no = 0; end
      else col_no = lts_pkg::pos_inc(col_no);
    end
    foreach (step_tok[i]) begin
      want_data.push_back(step_tok[i]);
      want_last.push_back(i == step_tok.size() - 1);
    end
  endfunction

  function void check_token(logic [63:0] d, logic l);
    logic [63:0] ed;
    bit el;
    if (want_data.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected token %h last %b", d, l);
      return;
    end
    ed = want_data.pop_front(); el = want_last.pop_front();
    if (d !== ed || l !== el) begin
      errors++;
      if (errors <= 10)
        $display({"token mismatch: cls %0d/%0d vt %0d/%0d len %0d/%0d c1 %h/%h c2 %h/%h",
                  " ln %0d/%0d col %0d/%0d last %b/%b (exp/got)"},
                 ed[4:0], d[4:0], ed[7:5], d[7:5], ed[14:8], d[14:8], ed[22:15], d[22:15],
                 ed[30:23], d[30:23], ed[46:31], d[46:31], ed[62:47], d[62:47], el, l);
    end
  endfunction
endclass

module tb_lexical_token_scanner;
  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, s_tuser = 0, m_tready = 0;
  logic [7:0]  s_tdata = 0;
  wire         s_tready, m_tvalid, m_tlast;
  wire  [63:0] m_tdata;
  bit          quiet = 0;  // no idling on either side
  bit          done = 0;
  token_scoreboard sb;

  lexical_token_scanner DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_token(m_tdata, m_tlast);

  always @(negedge clk) m_tready <= quiet || ($urandom_range(99) >= 10);

  // called at a falling edge; valid is dropped only for idle cycles
  task automatic send_char(input logic [7:0] c, input bit eoi);
    while (!quiet && $urandom_range(99) < 10) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1; s_tdata <= c; s_tuser <= eoi;
    do @(posedge clk); while (!s_tready);
    sb.note_request(c, eoi);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i], 0);
  endtask

  // random well-formed source fragment
  task automatic send_fragment();
    string kw[14] = '{"inicio", "varinicio", "varfim", "escreva", "leia", "se", "entao",
                      "fimse", "repita", "fimrepita", "fim", "inteiro", "literal", "real"};
    string seps[8] = '{" ", "\n", "\t", ";", ",", "(", ")", " "};
    string ops[10] = '{"<-", "<=", ">=", "==", "<", ">", "=", "+", "*", "."};
    case ($urandom_range(9))
      0, 1: send_text(kw[$urandom_range(13)]);
      2: repeat ($urandom_range(1, 6)) send_char(8'("a") + 8'($urandom_range(25)), 0);
      3: begin
        repeat ($urandom_range(1, 4)) send_char(8'("0") + 8'($urandom_range(9)), 0);
        if ($urandom_range(1)) send_text(".5");
        if ($urandom_range(1)) begin
          if ($urandom_range(1)) send_text("E-1");
          else send_text("e7");
        end
      end
      4: begin send_char("\"", 0); repeat ($urandom_range(0, 5)) send_char(8'($urandom), 0);
        send_char("'", 0); end
      5: send_text(ops[$urandom_range(9)]);
      6: begin send_char("{", 0); repeat ($urandom_range(0, 4)) send_char(8'($urandom), 0);
        send_char("}", 0); end
      7: send_char(8'($urandom), 0);
      default: ;
    endcase
    send_text(seps[$urandom_range(7)]);
  endtask

  initial begin
    int n;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 0;
    // directed: keywords, numbers, operators, specials, invalid bytes
    send_text("inicio x1_y:=3.5E+2<-'ab'<=>= ==}\r.,;()+-*/");
    send_char(8'hFF, 0); send_char(8'h00, 0);
    send_char("<", 0); send_char(8'h00, 1);
    // long identifier saturates
    repeat (70) send_char("a", 0);
    send_text("\"open");
    send_char(8'h55, 1);
    send_text("{x");
    send_char(8'hAA, 1);
    n = 0;
    while (n < 1050) begin
      quiet = (n >= 400 && n < 550);
      if ($urandom_range(9) == 0) begin
        send_char(8'($urandom), $urandom_range(19) == 0); n++;
      end
      else begin send_fragment(); n += 4; end
    end
    send_char(0, 1);
    s_tvalid <= 0;
    while (sb.want_data.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
src/lts_pkg.sv
src/lts_front.sv
src/lts_queue.sv
src/lexical_token_scanner.sv
bench/tb_lexical_token_scanner.sv
